// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("concurrent assertion failed");

// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== hdl/szt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sector zone tracker package
// Widths, field positions, sector windows and shared helper functions.
// ----------------------------------------------------------------------------
package szt_pkg;

    localparam int NUM_SECTORS = 12;
    localparam int SEC_W       = $clog2(NUM_SECTORS);
    localparam int ZONE_W      = 4;
    localparam logic [ZONE_W-1:0] ZONE_NONE = 4'd13;
    localparam int NUM_BANDS   = 12;
    localparam int NUM_THR     = NUM_BANDS + 1;

    localparam int QUAL_W   = 6;
    localparam int ANGLE_W  = 15;
    localparam int DIST_W   = 16;
    localparam int OFFSET_W = 16;
    localparam int WIDTH_W  = 14;
    localparam int THR_W    = 18;   // offset + 12 * width fits in 18 bits

    localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd1120;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 14'd1000;

    // configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_ZONE_OFFSET = 1'b0;
    localparam logic REG_ZONE_WIDTH  = 1'b1;

    // slave-side tdata: quality, angle, distance
    localparam int QUAL_LSB  = 0;
    localparam int ANGLE_LSB = QUAL_LSB + QUAL_W;
    localparam int DIST_LSB  = ANGLE_LSB + ANGLE_W;
    localparam int S_TDATA_W = 40;

    // master-side tdata: sector, zone, nearest, front, right, back, left
    localparam int M_TDATA_W = 32;
    localparam int RES_W     = M_TDATA_W + 1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        SIDE_FRONT,
        SIDE_RIGHT,
        SIDE_BACK,
        SIDE_LEFT
    } t_side;

    typedef struct packed {
        logic              hit;
        logic [SEC_W-1:0]  sector;
        t_side             side;
    } t_sec_hit;

    // read-modify-write request for the sector memory
    typedef struct packed {
        logic              valid;
        logic              clear;
        logic              hit;
        logic [SEC_W-1:0]  sector;
        logic [ZONE_W-1:0] zone;
    } t_mem_req;

    typedef logic [NUM_THR-1:0][THR_W-1:0] t_thr_vec;

    typedef struct packed {
        logic [ANGLE_W-1:0] lo;
        logic [ANGLE_W-1:0] hi;
        logic [SEC_W-1:0]   sector;
        t_side              side;
    } t_window;

    localparam int NUM_WINDOWS = 10;

    // angular windows, both bounds inclusive
    localparam t_window WINDOWS [NUM_WINDOWS] = '{
        '{15'd0,     15'd640,   4'd0,  SIDE_FRONT},
        '{15'd641,   15'd1280,  4'd1,  SIDE_RIGHT},
        '{15'd1281,  15'd2880,  4'd2,  SIDE_RIGHT},
        '{15'd7681,  15'd9600,  4'd4,  SIDE_BACK},
        '{15'd9601,  15'd11520, 4'd5,  SIDE_BACK},
        '{15'd11521, 15'd13440, 4'd6,  SIDE_BACK},
        '{15'd15361, 15'd17280, 4'd7,  SIDE_BACK},
        '{15'd20161, 15'd21440, 4'd9,  SIDE_LEFT},
        '{15'd21441, 15'd22080, 4'd10, SIDE_LEFT},
        '{15'd22081, 15'd22720, 4'd11, SIDE_FRONT}
    };

    function automatic t_sec_hit sector_lookup(input logic [ANGLE_W-1:0] angle);
        t_sec_hit res;
        res.hit    = 1'b0;
        res.sector = '0;
        res.side   = SIDE_FRONT;
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            if (angle >= WINDOWS[i].lo && angle <= WINDOWS[i].hi) begin
                res.hit    = 1'b1;
                res.sector = WINDOWS[i].sector;
                res.side   = WINDOWS[i].side;
            end
        end
        return res;
    endfunction

    // band limits: entry k is offset + k * width
    function automatic t_thr_vec band_limits(input logic [OFFSET_W-1:0] offset,
                                             input logic [WIDTH_W-1:0]  width);
        t_thr_vec lim;
        for (int k = 0; k < NUM_THR; k++) begin
            lim[k] = THR_W'(offset) + THR_W'(width) * THR_W'(k);
        end
        return lim;
    endfunction

endpackage

// ===== hdl/szt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Zone offset and width registers behind the bus port, plus registered band
// limits derived from them.
// ----------------------------------------------------------------------------
module szt_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [szt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [szt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [szt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output szt_pkg::t_thr_vec                 o_limits
);
    import szt_pkg::*;

    logic [OFFSET_W-1:0] r_zone_offset;
    logic [WIDTH_W-1:0]  r_zone_width;
    t_thr_vec            r_limits;
    logic                wr_en;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[REG_SEL_BIT];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_offset <= OFFSET_RST;
            r_zone_width  <= WIDTH_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_ZONE_OFFSET: r_zone_offset <= pwdata[OFFSET_W-1:0];
                REG_ZONE_WIDTH:  r_zone_width  <= pwdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // recompute every cycle; the limits are registered from the offset and width registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits <= band_limits(OFFSET_RST, WIDTH_RST);
        end else begin
            r_limits <= band_limits(r_zone_offset, r_zone_width);
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ZONE_OFFSET: prdata = APB_DATA_W'(r_zone_offset);
            REG_ZONE_WIDTH:  prdata = APB_DATA_W'(r_zone_width);
            default:         prdata = '0;
        endcase
    end

    assign o_limits = r_limits;

endmodule

// ===== hdl/szt_zone_mem.sv =====
// ----------------------------------------------------------------------------
// Sector zone memory
// Last zone per sector in a synchronous RAM, with per-entry valid bits,
// forwarding of the preceding item's write and the nearest-zone compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module szt_zone_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [szt_pkg::SEC_W-1:0]     i_rd_sector,
    input  szt_pkg::t_mem_req             i_req,
    output logic [szt_pkg::ZONE_W-1:0]    o_nearest
);
    import szt_pkg::*;

    logic [ZONE_W-1:0]      r_mem [NUM_SECTORS];
    logic [ZONE_W-1:0]      r_rd_data;
    logic [NUM_SECTORS-1:0] r_valid;
    logic [NUM_SECTORS-1:0] n_valid;
    logic                   r_fwd_valid;
    logic [SEC_W-1:0]       r_fwd_sector;
    logic [ZONE_W-1:0]      r_fwd_zone;
    logic [ZONE_W-1:0]      prev_zone;
    logic                   wr_en;

    assign wr_en = i_req.valid && i_req.hit;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_req.sector] <= i_req.zone;
        end
        r_rd_data <= r_mem[i_rd_sector];
    end

    // clear first, then mark the entry just written
    always_comb begin
        n_valid = r_valid;
        if (i_req.valid && i_req.clear) begin
            n_valid = '0;
        end
        if (wr_en) begin
            n_valid[i_req.sector] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_fwd_valid <= wr_en;
        end
        r_fwd_sector <= i_req.sector;
        r_fwd_zone   <= i_req.zone;
    end

    // the read was issued while the previous item was writing: forward it
    always_comb begin
        if (i_req.clear) begin
            prev_zone = ZONE_NONE;
        end else if (r_fwd_valid && r_fwd_sector == i_req.sector) begin
            prev_zone = r_fwd_zone;
        end else if (r_valid[i_req.sector]) begin
            prev_zone = r_rd_data;
        end else begin
            prev_zone = ZONE_NONE;
        end
    end

    assign o_nearest = (i_req.zone < prev_zone) ? i_req.zone : prev_zone;

    `ASSERT_PROP(a_nearest_le_zone, i_clk, i_rst_n, wr_en |-> o_nearest <= i_req.zone)
    `ASSERT_PROP(a_valid_after_write, i_clk, i_rst_n, wr_en |=> r_valid[$past(i_req.sector)])
    `ASSERT_PROP(a_clear_empties, i_clk, i_rst_n, i_req.valid && i_req.clear && !i_req.hit |=> r_valid == '0)
    `ASSERT_PROP(a_fwd_entry_valid, i_clk, i_rst_n, r_fwd_valid |-> r_valid[r_fwd_sector])

endmodule

// ===== hdl/szt_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Small queue with a registered output stage between the pipeline and the
// master-side stream.
// ----------------------------------------------------------------------------
module szt_result_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [szt_pkg::RES_W-1:0]     i_data,
    output logic                          o_valid,
    output logic [szt_pkg::RES_W-1:0]     o_data,
    input  logic                          i_ready
);
    import szt_pkg::*;

    logic [RES_W-1:0]      r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [OCC_W-1:0]      r_count;
    logic                  r_out_valid;
    logic [RES_W-1:0]      r_out_data;
    logic                  pop;
    logic                  load;

    assign pop  = r_out_valid && i_ready;
    assign load = (r_count != '0) && (!r_out_valid || pop);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (load) begin
            r_out_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (load) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + OCC_W'(i_push) - OCC_W'(load);
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// ===== hdl/sector_obstacle_zone_tracker.sv =====
// ----------------------------------------------------------------------------
// Sector obstacle zone tracker
// Path: stage 1, 2 and 3 registers, then the result queue and its output register.
// Throughput: one measurement per cycle while under 8 transactions are open; the
// sector memory read-modify-write with write forwarding sustains it.
// Reset: synchronous, clears valid bits so every sector reads zone 13,
// clears the four reports to 0 and loads default offset and width.
// ----------------------------------------------------------------------------
module sector_obstacle_zone_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [5:0] quality, [20:6] angle_q6, [36:21] range_q2, [39:37] zero
    input  logic [szt_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [0] start_of_scan
    input  logic [0:0]                        i_s_tuser,
    // master side
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [3:0] sector, [7:4] zone, [11:8] nearest_zone, [15:12] front_zone,
    // [19:16] right_zone, [23:20] back_zone, [27:24] left_zone, [31:28] zero
    output logic [szt_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // [0] in_sector
    output logic [0:0]                        o_m_tuser,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [szt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [szt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [szt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import szt_pkg::*;

    typedef struct packed {
        logic              clear;
        logic              hit;
        logic [SEC_W-1:0]  sector;
        t_side             side;
        logic [DIST_W-1:0] range_q2;
    } t_item;

    // band of a distance: first band whose upper limit reaches it
    function automatic logic [ZONE_W-1:0] band_of(input logic [DIST_W-1:0] d,
                                                  input t_thr_vec lim);
        logic [ZONE_W-1:0] z;
        z = ZONE_NONE;
        for (int k = NUM_BANDS; k >= 1; k--) begin
            if (THR_W'(d) <= lim[k]) begin
                z = ZONE_W'(k);
            end
        end
        if (THR_W'(d) <= lim[0]) begin
            z = ZONE_NONE;
        end
        return z;
    endfunction

    t_thr_vec          limits;
    logic              s_fire;
    logic              m_fire;
    logic [OCC_W-1:0]  r_occ;
    t_sec_hit          dec;
    t_item             in_item;

    logic              r_s1_valid;
    t_item             r_s1;
    logic              r_s2_valid;
    t_item             r_s2;
    logic              r_s3_valid;
    t_item             r_s3;
    logic [ZONE_W-1:0] r_s3_zone;

    t_mem_req          mem_req;
    logic [ZONE_W-1:0] mem_nearest;

    logic [ZONE_W-1:0] r_front;
    logic [ZONE_W-1:0] r_right;
    logic [ZONE_W-1:0] r_back;
    logic [ZONE_W-1:0] r_left;
    logic [ZONE_W-1:0] n_front;
    logic [ZONE_W-1:0] n_right;
    logic [ZONE_W-1:0] n_back;
    logic [ZONE_W-1:0] n_left;
    logic [ZONE_W-1:0] res_zone;
    logic [ZONE_W-1:0] res_nearest;
    logic [RES_W-1:0]  res_word;
    logic [RES_W-1:0]  fifo_data;

    szt_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (limits)
    );

    // Accept only while every open transaction has a queue slot waiting.
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign m_fire     = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_occ < OCC_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + OCC_W'(s_fire) - OCC_W'(m_fire);
        end
    end

    // Stage 1: decode the angle window; a zero quality marks the sample as unused.
    always_comb begin
        dec              = sector_lookup(i_s_tdata[ANGLE_LSB +: ANGLE_W]);
        in_item.clear    = i_s_tuser[0];
        in_item.hit      = dec.hit && (i_s_tdata[QUAL_LSB +: QUAL_W] != '0);
        in_item.sector   = in_item.hit ? dec.sector : '0;
        in_item.side     = dec.side;
        in_item.range_q2 = i_s_tdata[DIST_LSB +: DIST_W];
    end

    // Stage 2 is an extra register so band limits reflect a write made with the
    // accepting edge. Stage 3 holds the band and the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= s_fire;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
        r_s1      <= in_item;
        r_s2      <= r_s1;
        r_s3      <= r_s2;
        r_s3_zone <= band_of(r_s2.range_q2, limits);
    end

    // Stage 3: read-modify-write of the sector's last zone.
    always_comb begin
        mem_req.valid  = r_s3_valid;
        mem_req.clear  = r_s3.clear;
        mem_req.hit    = r_s3.hit;
        mem_req.sector = r_s3.sector;
        mem_req.zone   = r_s3_zone;
    end

    szt_zone_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_sector (r_s2.sector),
        .i_req       (mem_req),
        .o_nearest   (mem_nearest)
    );

    // Route the nearest zone to the report its sector feeds.
    always_comb begin
        n_front = r_front;
        n_right = r_right;
        n_back  = r_back;
        n_left  = r_left;
        if (r_s3_valid && r_s3.hit) begin
            case (r_s3.side)
                SIDE_FRONT: n_front = mem_nearest;
                SIDE_RIGHT: n_right = mem_nearest;
                SIDE_BACK:  n_back  = mem_nearest;
                default:    n_left  = mem_nearest;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_right <= '0;
            r_back  <= '0;
            r_left  <= '0;
        end else begin
            r_front <= n_front;
            r_right <= n_right;
            r_back  <= n_back;
            r_left  <= n_left;
        end
    end

    // Unused samples report zone 13; only a start of scan on one changes state.
    assign res_zone    = r_s3.hit ? r_s3_zone : ZONE_NONE;
    assign res_nearest = r_s3.hit ? mem_nearest : ZONE_NONE;
    assign res_word    = {r_s3.hit, 4'b0000, n_left, n_back, n_right, n_front,
                          res_nearest, res_zone, r_s3.sector};

    szt_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_valid),
        .i_data  (res_word),
        .o_valid (o_m_tvalid),
        .o_data  (fifo_data),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = fifo_data[M_TDATA_W-1:0];
    assign o_m_tuser = fifo_data[RES_W-1 -: 1];

endmodule

// ===== tb/tb_sector_obstacle_zone_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sector obstacle zone tracker testbench
// Streams lidar measurements into the tracker and checks every result against
// a cycle-free model of the sector memory, the distance bands and the four
// side reports. Covers window edges, band edges, unused samples, start of
// scan, several band settings, random slave-side gaps and master-side back-pressure.
// ----------------------------------------------------------------------------
module tb_sector_obstacle_zone_tracker;

    import szt_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_AFTER   = 150;   // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 300;

    localparam logic [APB_ADDR_W-1:0] ADDR_ZONE_OFFSET =
        APB_ADDR_W'(REG_ZONE_OFFSET) << REG_SEL_BIT;
    localparam logic [APB_ADDR_W-1:0] ADDR_ZONE_WIDTH =
        APB_ADDR_W'(REG_ZONE_WIDTH) << REG_SEL_BIT;

    // one measurement as it goes onto the slave side
    typedef struct packed {
        logic               sos;
        logic [QUAL_W-1:0]  quality;
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  range_q2;
    } t_meas;

    // result fields: 0 in_sector, 1 sector, 2 zone, 3 nearest_zone,
    // 4 front, 5 right, 6 back, 7 left
    typedef logic [7:0][3:0] t_zone_fields;

    typedef struct {
        int          lo;
        int          hi;
        logic [3:0]  sector;
        t_side       side;
    } t_window_def;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;
    logic [0:0]            i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [0:0]            o_m_tuser;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sector_obstacle_zone_tracker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // model state: band setting, per-sector memory and side reports
    int         zone_offset = int'(OFFSET_RST);
    int         zone_width  = int'(WIDTH_RST);
    logic [3:0] last_zone   [NUM_SECTORS];
    logic [3:0] side_report [4];

    t_meas        meas_to_send [$];
    t_zone_fields zone_reports_due [$];

    int   errors       = 0;
    int   results_seen = 0;
    int   cycles       = 0;
    bit   burst_phase  = 1'b0;   // no new random gaps or stalls are drawn while set
    bit   offered      = 1'b0;
    int   send_gap     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    t_meas cur         = '0;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // watched windows, both bounds inclusive
    function automatic t_window_def window_def(input int i);
        t_window_def w;
        case (i)
            0: w = '{0,     640,   4'd0,  SIDE_FRONT};
            1: w = '{641,   1280,  4'd1,  SIDE_RIGHT};
            2: w = '{1281,  2880,  4'd2,  SIDE_RIGHT};
            3: w = '{7681,  9600,  4'd4,  SIDE_BACK};
            4: w = '{9601,  11520, 4'd5,  SIDE_BACK};
            5: w = '{11521, 13440, 4'd6,  SIDE_BACK};
            6: w = '{15361, 17280, 4'd7,  SIDE_BACK};
            7: w = '{20161, 21440, 4'd9,  SIDE_LEFT};
            8: w = '{21441, 22080, 4'd10, SIDE_LEFT};
            default: w = '{22081, 22720, 4'd11, SIDE_FRONT};
        endcase
        return w;
    endfunction

    // band k covers offset + width*(k-1) < d <= offset + width*k
    function automatic logic [3:0] band_of(input logic [DIST_W-1:0] d);
        int k;
        if (zone_width == 0 || int'(d) <= zone_offset) return ZONE_NONE;
        k = (int'(d) - zone_offset - 1) / zone_width + 1;
        return (k > 12) ? ZONE_NONE : 4'(k);
    endfunction

    // apply one measurement to the model and return the result it produces
    function automatic t_zone_fields track_measurement(input t_meas m);
        t_zone_fields r;
        t_window_def  wd;
        logic [3:0]   zone;
        logic [3:0]   prev;
        logic [3:0]   nearest;
        r = '0;
        r[2] = ZONE_NONE;
        r[3] = ZONE_NONE;
        if (m.sos) begin
            for (int s = 0; s < NUM_SECTORS; s++) last_zone[s] = ZONE_NONE;
        end
        if (m.quality != '0) begin
            // windows are disjoint, so at most one matches
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                wd = window_def(i);
                if (int'(m.angle) >= wd.lo && int'(m.angle) <= wd.hi) begin
                    prev    = last_zone[wd.sector];
                    zone    = band_of(m.range_q2);
                    nearest = (zone < prev) ? zone : prev;
                    last_zone[wd.sector]  = zone;
                    side_report[int'(wd.side)] = nearest;
                    r[0] = 4'd1;
                    r[1] = wd.sector;
                    r[2] = zone;
                    r[3] = nearest;
                end
            end
        end
        r[4] = side_report[int'(SIDE_FRONT)];
        r[5] = side_report[int'(SIDE_RIGHT)];
        r[6] = side_report[int'(SIDE_BACK)];
        r[7] = side_report[int'(SIDE_LEFT)];
        return r;
    endfunction

    function automatic string field_name(input int k);
        case (k)
            0: return "in_sector";
            1: return "sector";
            2: return "zone";
            3: return "nearest_zone";
            4: return "front_zone";
            5: return "right_zone";
            6: return "back_zone";
            default: return "left_zone";
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (burst_phase || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // random measurement aimed at windows and bands of the current setting
    function automatic t_meas make_meas();
        t_meas       m;
        t_window_def wd;
        int          r;
        int          d;
        wd = window_def($urandom_range(0, NUM_WINDOWS - 1));
        m.sos     = ($urandom_range(0, 99) < 4);
        m.quality = ($urandom_range(0, 99) < 8) ? '0 : QUAL_W'($urandom_range(1, 63));
        r = $urandom_range(0, 99);
        if (r < 80)      m.angle = ANGLE_W'($urandom_range(wd.lo, wd.hi));
        else if (r < 90) m.angle = ANGLE_W'(($urandom_range(0, 1) != 0) ? wd.hi + 1
                                                                      : wd.lo - 1 + (wd.lo == 0));
        else             m.angle = ANGLE_W'($urandom_range(0, 32767));
        r = $urandom_range(0, 99);
        if (r < 70)      d = zone_offset + $urandom_range(0, 13 * zone_width + 2);
        else if (r < 80) d = zone_offset + zone_width * $urandom_range(0, 13)
                             + $urandom_range(0, 1);
        else             d = $urandom_range(0, 65535);
        m.range_q2 = (d > 65535) ? 16'hFFFF : DIST_W'(d);
        return m;
    endfunction

    // hold until nothing is queued, offered or outstanding, then let it settle
    task automatic wait_idle();
        while (meas_to_send.size() != 0 || offered || zone_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_bands(input int offset, input int width);
        wait_idle();
        reg_write(ADDR_ZONE_OFFSET, offset);
        reg_write(ADDR_ZONE_WIDTH, width);
        zone_offset = offset;
        zone_width  = width;
        @(posedge i_clk);
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) meas_to_send.push_back(make_meas());
    endtask

    // ------------------------------------------------------------------------
    // Slave-side driver: offer queued measurements, predict on each transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            offered    = 1'b0;
            send_gap   = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                zone_reports_due.push_back(track_measurement(cur));
                offered = 1'b0;
            end
            if (!offered) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (meas_to_send.size() > 0) begin
                    cur      = meas_to_send.pop_front();
                    offered  = 1'b1;
                    send_gap = idle_length();
                end
            end
            i_s_tvalid <= offered;
            i_s_tdata  <= {3'b000, cur.range_q2, cur.angle, cur.quality};
            i_s_tuser  <= cur.sos;
        end
    end

    // ------------------------------------------------------------------------
    // Master-side monitor: compare each transaction, drive random back-pressure
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : receiver
        t_zone_fields got;
        t_zone_fields want;
        logic         ready_next;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got[0] = {3'b000, o_m_tuser[0]};
                for (int k = 1; k < 8; k++) got[k] = o_m_tdata[4*(k-1) +: 4];
                if (zone_reports_due.size() == 0) begin
                    $display("%0t: unexpected result, tdata %h tuser %b",
                             $time, o_m_tdata, o_m_tuser);
                    errors++;
                end else begin
                    want = zone_reports_due.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (want[k] !== got[k]) begin
                            $display("%0t: %s expected %0d, actual %0d",
                                     $time, field_name(k), want[k], got[k]);
                            errors++;
                        end
                    end
                end
                results_seen++;
                // once, drop ready for a long stretch so the block backs up
                if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                if (!burst_phase && $urandom_range(0, 99) < 25) stall_left = idle_length();
            end
            i_m_tready <= ready_next;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        // window edges, just outside edges and the top of the angle range
        int dir_angle [23] = '{0, 640, 641, 1280, 1281, 2880, 2881, 7681, 9600,
                               9601, 11520, 11521, 13440, 15361, 17280, 20161,
                               21440, 21441, 22080, 22081, 22720, 22721, 32767};
        // offset edge, first band edges, top band edge, extremes
        int dir_dist [8] = '{0, 1120, 1121, 2120, 2121, 13120, 13121, 65535};
        t_meas m;

        for (int s = 0; s < NUM_SECTORS; s++) last_zone[s] = ZONE_NONE;
        for (int s = 0; s < 4; s++) side_report[s] = 4'd0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset band setting
        for (int i = 0; i < 23; i++) begin
            m.sos      = (i == 0);
            m.quality  = (i == 0) ? 6'd63 : (i == 1) ? 6'd1 : QUAL_W'($urandom_range(1, 63));
            m.angle    = ANGLE_W'(dir_angle[i]);
            m.range_q2 = DIST_W'(dir_dist[i % 8]);
            meas_to_send.push_back(m);
        end
        // zero quality in a watched window: ignored
        meas_to_send.push_back('{1'b0, 6'd0, 15'd100, 16'd2000});
        // start of scan on an ignored sample still clears sector memory
        meas_to_send.push_back('{1'b1, 6'd0, 15'd0, 16'd1500});
        meas_to_send.push_back('{1'b0, 6'd42, 15'd0, 16'd65535});
        queue_random(80);

        // narrowest bands right at zero distance
        burst_phase = 1'b1;
        set_bands(0, 1);
        queue_random(70);

        // widest setting: every distance at or below the offset
        burst_phase = 1'b0;
        set_bands(65535, 16383);
        queue_random(30);

        burst_phase = 1'b1;
        set_bands(0, 16383);
        queue_random(60);

        // zero width leaves every band empty
        burst_phase = 1'b0;
        set_bands(0, 0);
        queue_random(30);

        burst_phase = 1'b1;
        set_bands($urandom_range(0, 65535), $urandom_range(1, 16383));
        queue_random(70);

        burst_phase = 1'b0;
        set_bands($urandom_range(0, 20000), $urandom_range(1, 4000));
        queue_random(70);

        set_bands(int'(OFFSET_RST), int'(WIDTH_RST));
        queue_random(40);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
